// ===== hdl/pwca_pkg.sv =====
// pwca_pkg: shared types and constants of the phase window channel accumulator
// used by every module of the block, no dependencies

package pwca_pkg;

  localparam int TIME_W   = 48;
  localparam int CNT_W    = 16;
  localparam int ERR_W    = 16;
  localparam int PHCFG_W  = 7;
  localparam int ROWIDX_W = 16;
  localparam int CHAN_W   = 4;
  localparam int SUM_W    = 22;
  localparam int SQ_W     = 38;
  localparam int ROOT_W   = 19;
  localparam int REM_W    = 21;
  localparam int REMSH_W  = 23;
  localparam int PHB_W    = 9;
  localparam int SQRT_STEPS  = 19;
  localparam int SQRT_STEP_W = 5;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_STOP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_PHASE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_PHASE   = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0]  win_start;
    logic [TIME_W-1:0]  win_stop;
    logic [PHCFG_W-1:0] first_phase;
    logic [PHCFG_W-1:0] last_phase;
  } cfg_t;

  // finished channel sums waiting for the square root
  typedef struct packed {
    logic                last;
    logic [TIME_W-1:0]   duration;
    logic [TIME_W-1:0]   start;
    logic [SQ_W-1:0]     sq_sum;
    logic [SUM_W-1:0]    sum;
    logic [CHAN_W-1:0]   channel;
    logic [ROWIDX_W-1:0] row_index;
  } rec_t;

  typedef struct packed {
    logic                last;
    logic [TIME_W-1:0]   duration;
    logic [TIME_W-1:0]   start;
    logic [ROOT_W-1:0]   error;
    logic [SUM_W-1:0]    sum;
    logic [CHAN_W-1:0]   channel;
    logic [ROWIDX_W-1:0] row_index;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_HOLD
  } bk_state_t;

endpackage

// ===== hdl/pwca_front.sv =====
// pwca_front: bin counters, window check and per-channel accumulation
// depends on pwca_pkg; pushes finished channel records into pwca_queue

module pwca_front import pwca_pkg::*; #(
  parameter int BINS_PER_ROW = 1024,
  parameter int PHASES       = 64,
  parameter int MAX_ROWS     = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TIME_W-1:0] row_start_time,
  input  logic [TIME_W-1:0] row_stop_time,
  input  logic [CNT_W-1:0]  bin_count,
  input  logic [ERR_W-1:0]  bin_error,
  input  logic              q_full,
  output logic              q_push,
  output rec_t              q_data
);

  localparam int POS_W = (BINS_PER_ROW > 1) ? $clog2(BINS_PER_ROW) : 1;
  localparam int PH_W  = (PHASES > 1) ? $clog2(PHASES) : 1;
  localparam int ROW_LIM = (MAX_ROWS - 1 > 65535) ? 65535 : MAX_ROWS - 1;

  logic [POS_W-1:0]    pos_r;
  logic [PH_W-1:0]     phase_r;
  logic [CHAN_W-1:0]   chan_r;
  logic                row_sel_r;
  logic [SUM_W-1:0]    cnt_acc_r, cnt_acc_nxt;
  logic [SQ_W-1:0]     sq_acc_r, sq_acc_nxt;
  logic [TIME_W-1:0]   start_r;
  logic [TIME_W-1:0]   dur_r;
  logic [ROWIDX_W-1:0] rows_r;

  logic              accept;
  logic              row_end;
  logic              phase_last;
  logic              emit;
  logic              incl;
  logic [PHB_W-1:0]  one_based;
  logic [SUM_W-1:0]  cnt_base;
  logic [SQ_W-1:0]   sq_base;
  logic [SUM_W:0]    cnt_sum;
  logic [2*ERR_W-1:0] sq_prod;
  logic [SQ_W:0]     sq_sum;

  assign row_end    = (pos_r == POS_W'(BINS_PER_ROW - 1));
  assign phase_last = (phase_r == PH_W'(PHASES - 1));
  // a record is only produced at the last phase of a channel, and only for a row whose window check passed
  assign emit       = phase_last && row_sel_r;
  assign in_ready   = !(emit && q_full);
  assign accept     = in_valid && in_ready;

  always_comb begin
    one_based = PHB_W'(phase_r) + PHB_W'(1);
    incl = (one_based >= PHB_W'(cfg.first_phase)) && (one_based <= PHB_W'(cfg.last_phase));
    cnt_base = (phase_r == '0) ? '0 : cnt_acc_r;
    sq_base  = (phase_r == '0) ? '0 : sq_acc_r;
    cnt_sum  = {1'b0, cnt_base} + (SUM_W+1)'(bin_count);
    sq_prod  = bin_error * bin_error;
    sq_sum   = {1'b0, sq_base} + (SQ_W+1)'(sq_prod);
    cnt_acc_nxt = cnt_base;
    sq_acc_nxt  = sq_base;
    if (incl) begin
      cnt_acc_nxt = cnt_sum[SUM_W] ? '1 : cnt_sum[SUM_W-1:0];
      sq_acc_nxt  = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
    end
  end

  always_comb begin
    q_push           = accept && emit;
    q_data.row_index = rows_r;
    q_data.channel   = chan_r;
    q_data.sum       = cnt_acc_nxt;
    q_data.sq_sum    = sq_acc_nxt;
    q_data.start     = start_r;
    q_data.duration  = dur_r;
    q_data.last      = row_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      phase_r   <= '0;
      chan_r    <= '0;
      row_sel_r <= 1'b0;
      cnt_acc_r <= '0;
      sq_acc_r  <= '0;
      start_r   <= '0;
      dur_r     <= '0;
      rows_r    <= '0;
    end else if (accept) begin
      cnt_acc_r <= cnt_acc_nxt;
      sq_acc_r  <= sq_acc_nxt;
      if (pos_r == '0) begin
        row_sel_r <= (row_start_time >= cfg.win_start) && (row_stop_time <= cfg.win_stop);
        start_r   <= row_start_time;
        dur_r     <= (row_stop_time >= row_start_time) ? (row_stop_time - row_start_time) : '0;
      end
      if (row_end) begin
        pos_r   <= '0;
        phase_r <= '0;
        chan_r  <= '0;
        if (row_sel_r && (rows_r < ROWIDX_W'(ROW_LIM)))
          rows_r <= rows_r + 1'b1;
      end else begin
        pos_r <= pos_r + 1'b1;
        if (phase_last) begin
          phase_r <= '0;
          chan_r  <= chan_r + 1'b1;
        end else begin
          phase_r <= phase_r + 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/pwca_queue.sv =====
// pwca_queue: two-entry queue of channel records between front and back
// depends on pwca_pkg

module pwca_queue import pwca_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_data,
  input  logic pop,
  output rec_t pop_data,
  output logic full,
  output logic empty
);

  rec_t       mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push)
      mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push)
        wr_ptr_r <= ~wr_ptr_r;
      if (pop)
        rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== hdl/pwca_back.sv =====
// pwca_back: bit-serial floor square root and output register
// depends on pwca_pkg; pops records from pwca_queue

module pwca_back import pwca_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  rec_t q_data,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  bk_state_t state_r, state_nxt;
  rec_t                   rec_r, rec_nxt;
  logic [SQ_W-1:0]        v_r, v_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic [ROOT_W-1:0]      root_r, root_nxt;
  logic [SQRT_STEP_W-1:0] step_r, step_nxt;
  res_t                   res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [REMSH_W-1:0] rem_sh;
  logic [REMSH_W-1:0] trial;
  logic [REMSH_W-1:0] rem_sub;
  logic               ge;

  // one result bit per step, two radicand bits brought down
  always_comb begin
    rem_sh  = {rem_r, v_r[SQ_W-1:SQ_W-2]};
    trial   = {2'b00, root_r, 2'b01};
    ge      = (rem_sh >= trial);
    rem_sub = rem_sh - trial;
  end

  always_comb begin
    state_nxt     = state_r;
    rec_nxt       = rec_r;
    v_nxt         = v_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    step_nxt      = step_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          rec_nxt   = q_data;
          v_nxt     = q_data.sq_sum;
          rem_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          state_nxt = BK_CALC;
        end
      end
      BK_CALC: begin
        v_nxt    = {v_r[SQ_W-3:0], 2'b00};
        rem_nxt  = ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == SQRT_STEP_W'(SQRT_STEPS - 1))
          state_nxt = BK_HOLD;
      end
      BK_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt     = 1'b1;
          res_nxt.row_index = rec_r.row_index;
          res_nxt.channel   = rec_r.channel;
          res_nxt.sum       = rec_r.sum;
          res_nxt.error     = root_r;
          res_nxt.start     = rec_r.start;
          res_nxt.duration  = rec_r.duration;
          res_nxt.last      = rec_r.last;
          if (!q_empty) begin
            q_pop = 1'b1;
            rec_nxt   = q_data;
            v_nxt     = q_data.sq_sum;
            rem_nxt   = '0;
            root_nxt  = '0;
            step_nxt  = '0;
            state_nxt = BK_CALC;
          end else begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r  <= rec_nxt;
    v_r    <= v_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    step_r <= step_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

endmodule

// ===== hdl/phase_window_channel_accumulator_core.sv =====
// phase_window_channel_accumulator_core: top level with configuration registers
// depends on pwca_pkg, pwca_front, pwca_queue, pwca_back
// throughput: one bin per cycle while in_tready is high; the square root unit
// works on one channel result at a time, so in_tready drops at a last phase only when
// the two-entry queue is full (never at PHASES >= 21 with a ready sink)
// each result passes the queue, the bit-serial square root and the output register
// reset: synchronous rst_n clears counters, sums and queue, and restores registers

module phase_window_channel_accumulator_core import pwca_pkg::*; #(
  parameter int BINS_PER_ROW = 1024,
  parameter int PHASES       = 64,
  parameter int MAX_ROWS     = 65536
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // row_start_time[47:0], row_stop_time[95:48], bin_count[111:96], bin_error[127:112]
  input  logic [127:0]         in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // row_index[15:0], channel[19:16], channel_sum[41:20], channel_error[60:42],
  // start_time[108:61], row_duration[156:109], zero pad[159:157]
  output logic [159:0]         out_tdata,
  output logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data
);

  cfg_t cfg_r;
  logic q_full, q_empty, q_push, q_pop;
  rec_t q_in, q_out;
  res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.win_start   <= '0;
      cfg_r.win_stop    <= '1;
      cfg_r.first_phase <= PHCFG_W'(1);
      cfg_r.last_phase  <= PHCFG_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_START: cfg_r.win_start   <= cfg_data;
        REG_WINDOW_STOP:  cfg_r.win_stop    <= cfg_data;
        REG_FIRST_PHASE:  cfg_r.first_phase <= cfg_data[PHCFG_W-1:0];
        REG_LAST_PHASE:   cfg_r.last_phase  <= cfg_data[PHCFG_W-1:0];
        default:          cfg_r <= cfg_r;
      endcase
    end
  end

  pwca_front #(
    .BINS_PER_ROW (BINS_PER_ROW),
    .PHASES       (PHASES),
    .MAX_ROWS     (MAX_ROWS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .row_start_time (in_tdata[47:0]),
    .row_stop_time  (in_tdata[95:48]),
    .bin_count      (in_tdata[111:96]),
    .bin_error      (in_tdata[127:112]),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_in)
  );

  pwca_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  pwca_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  assign out_tdata = {3'b000, res.duration, res.start, res.error, res.sum, res.channel,
                      res.row_index};
  assign out_tlast = res.last;

endmodule
